// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the project checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- design/lgs_pkg.sv -----
// ----------------------------------------------------------------------------
// lgs_pkg
// Types and constants shared by the Life generation step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lgs_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 32;

  localparam int ROW_IDX_W = $clog2(GRID_HEIGHT);
  localparam int COL_IDX_W = $clog2(GRID_WIDTH);
  localparam int NBR_W     = 4;

  localparam logic [NBR_W-1:0] BIRTH_COUNT   = NBR_W'(3);
  localparam logic [NBR_W-1:0] SURVIVE_COUNT = NBR_W'(2);

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] col;
    logic [4:0] row;
    logic       alive_in;
  } cmd_t;

  typedef struct packed {
    logic       cell_out;
    logic [1:0] op_done;
  } res_t;

  // Control shared by every row cell of the chain.
  typedef struct packed {
    logic                 shift;
    logic [COL_IDX_W-1:0] wr_col;
    logic                 wr_val;
  } cell_ctrl_t;

endpackage

// ----- design/lgs_row_cell.sv -----
// ----------------------------------------------------------------------------
// lgs_row_cell
// One grid row; loads its shift input on a chain shift, else one cell write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgs_row_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  lgs_pkg::cell_ctrl_t             ctrl,
  input  logic                            wr_sel,
  input  logic [lgs_pkg::GRID_WIDTH-1:0]  shift_in,
  output logic [lgs_pkg::GRID_WIDTH-1:0]  row_bits
);
  import lgs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bits <= '0;
    end else if (ctrl.shift) begin
      row_bits <= shift_in;
    end else if (wr_sel) begin
      row_bits[ctrl.wr_col] <= ctrl.wr_val;
    end
  end

endmodule

// ----- design/lgs_next_row.sv -----
// ----------------------------------------------------------------------------
// lgs_next_row
// B3/S23 rule applied to one row from its upper, own and lower old rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgs_next_row (
  input  logic [lgs_pkg::GRID_WIDTH-1:0] above,
  input  logic [lgs_pkg::GRID_WIDTH-1:0] center,
  input  logic [lgs_pkg::GRID_WIDTH-1:0] below,
  output logic [lgs_pkg::GRID_WIDTH-1:0] next_bits
);
  import lgs_pkg::*;

  logic [GRID_WIDTH+1:0] up_pad, mid_pad, dn_pad;
  logic [NBR_W-1:0]      cnt;

  // A dead column on each side stands for the cells beyond the edge.
  assign up_pad  = {1'b0, above, 1'b0};
  assign mid_pad = {1'b0, center, 1'b0};
  assign dn_pad  = {1'b0, below, 1'b0};

  always_comb begin
    cnt       = '0;
    next_bits = '0;
    for (int c = 0; c < GRID_WIDTH; c++) begin
      cnt = NBR_W'(up_pad[c]) + NBR_W'(up_pad[c+1]) + NBR_W'(up_pad[c+2]) +
            NBR_W'(mid_pad[c]) + NBR_W'(mid_pad[c+2]) +
            NBR_W'(dn_pad[c]) + NBR_W'(dn_pad[c+1]) + NBR_W'(dn_pad[c+2]);
      next_bits[c] = (cnt == BIRTH_COUNT) || (mid_pad[c+1] && cnt == SURVIVE_COUNT);
    end
  end

endmodule

// ----- design/life_generation_step.sv -----
// ----------------------------------------------------------------------------
// life_generation_step
// Bounded Conway Life grid with cell write, cell read and generation step.
// ----------------------------------------------------------------------------
// A command transfers at a clock edge where start is high and busy is low.
// Write, read and the unused op code finish in one cycle: done pulses for
// one cycle in the next cycle with the result, and busy stays low, so a new
// command may be given in that same cycle. For a generation step the rows
// sit in a chain of row cells that rotates one row per cycle past a single
// rule stage, which writes the new row at the tail while a register keeps
// the old row above. Busy is high while the chain rotates. The result stays
// on the result ports until the next result replaces it, with done high
// for one cycle; there is no way to hold it off, so the receiver must take
// it when done is high.
`timescale 1ns / 1ps

module life_generation_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  lgs_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output lgs_pkg::res_t result
);
  import lgs_pkg::*;

  logic [GRID_WIDTH-1:0]  rows [GRID_HEIGHT];
  logic [GRID_HEIGHT-1:0] wr_sel;
  logic [GRID_WIDTH-1:0]  prev_row, below_row, new_row;
  logic [ROW_IDX_W-1:0]   step_cnt, row_idx;
  logic [COL_IDX_W-1:0]   col_idx;
  logic                   accept, step_last, in_grid, is_write;
  cell_ctrl_t             ctrl;

  assign accept    = start && !busy;
  assign row_idx   = ROW_IDX_W'(cmd.row);
  assign col_idx   = COL_IDX_W'(cmd.col);
  assign in_grid   = (32'(cmd.col) < GRID_WIDTH) && (32'(cmd.row) < GRID_HEIGHT);
  assign is_write  = accept && (cmd.op == OP_WRITE) && in_grid;
  assign step_last = (step_cnt == ROW_IDX_W'(GRID_HEIGHT - 1));

  assign ctrl.shift  = busy;
  assign ctrl.wr_col = col_idx;
  assign ctrl.wr_val = cmd.alive_in;

  // On the last step the row below the head is already a new row 0,
  // so the bottom edge is fed as dead.
  assign below_row = step_last ? '0 : rows[1];

  lgs_next_row u_rule (
    .above     (prev_row),
    .center    (rows[0]),
    .below     (below_row),
    .next_bits (new_row)
  );

  // The tail cell takes the freshly computed row; the rest take the next cell.
  for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_link
    logic [GRID_WIDTH-1:0] link_in;
    assign wr_sel[i] = is_write && (row_idx == ROW_IDX_W'(i));
    assign link_in = (i == GRID_HEIGHT - 1) ? new_row : rows[(i + 1) % GRID_HEIGHT];

    lgs_row_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .wr_sel   (wr_sel[i]),
      .shift_in (link_in),
      .row_bits (rows[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        if (cmd.op == OP_STEP) begin
          busy     <= 1'b1;
          step_cnt <= '0;
        end else begin
          done <= 1'b1;
        end
      end
      if (busy) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_row <= '0;
      if (cmd.op != OP_STEP) begin
        result.cell_out <= (cmd.op == OP_READ) && in_grid && rows[row_idx][col_idx];
        result.op_done  <= cmd.op;
      end
    end else if (busy) begin
      prev_row <= rows[0];
      if (step_last) begin
        result.cell_out <= 1'b0;
        result.op_done  <= OP_STEP;
      end
    end
  end

endmodule

// ----- design/lgs_checker.sv -----
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks of command and result timing for the Life block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lgs_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input lgs_pkg::cmd_t cmd,
  input lgs_pkg::res_t result
);
  import lgs_pkg::*;

  logic fast_xfer, step_xfer;

  assign fast_xfer = start && !busy && (cmd.op != OP_STEP);
  assign step_xfer = start && !busy && (cmd.op == OP_STEP);

  // Only a read may return a live cell.
  `ASSERT_SAME(a_cell_only_on_read, clk, rst, done && result.op_done != OP_READ, !result.cell_out)

  // A write, read or unused op command answers in the next cycle with its own op code.
  `ASSERT_NEXT(a_fast_done, clk, rst, fast_xfer, done && result.op_done == $past(cmd.op))

  // A step transfer starts a busy period with no result yet.
  `ASSERT_NEXT(a_step_busy, clk, rst, step_xfer, busy && !done)

  // The end of a busy period is the step result.
  `ASSERT_SAME(a_step_done, clk, rst, $fell(busy) && !$past(rst), done && result.op_done == OP_STEP)

endmodule

bind life_generation_step lgs_checker u_lgs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .cmd    (cmd),
  .result (result)
);
